### hdl/ipa_pkg.sv
// ipa_pkg: shared constants, types and bit-search helpers for the identifier
// pool allocator. No dependencies; imported by every other file in hdl/.
package ipa_pkg;

    localparam int ID_COUNT   = 256;
    localparam int VOID_ID    = 0;
    localparam int MAP_DEPTH  = 256;
    localparam int ID_LIMIT   = (ID_COUNT < MAP_DEPTH) ? ID_COUNT : MAP_DEPTH;
    localparam int ID_W       = $clog2(MAP_DEPTH);
    localparam int WORD_W     = 16;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WORD_COUNT = MAP_DEPTH / WORD_W;
    localparam int ADDR_W     = $clog2(WORD_COUNT);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int OP_W       = 2;
    localparam int ST_W       = 2;

    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_NEXT     = 2'd0;
    localparam op_t OP_SPECIFIC = 2'd1;
    localparam op_t OP_RELEASE  = 2'd2;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_TAKEN     = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACCESS,
        S_MODIFY,
        S_REPLY
    } state_t;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t assigned;
        word_t released;
    } map_rd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        word_t             assigned;
        word_t             released;
    } map_wr_t;

    function automatic logic [BIT_W-1:0] lowest_bit(input word_t w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (w[i])
                idx = BIT_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [BIT_W-1:0] highest_bit(input word_t w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (w[i])
                idx = BIT_W'(i);
        end
        return idx;
    endfunction

endpackage

### hdl/ipa_if.sv
// ipa_in_if / ipa_out_if: valid/ready channels for request and response words.
// Depends on ipa_pkg for field widths.
interface ipa_in_if;
    import ipa_pkg::*;
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] operation;
    logic [ID_W-1:0] request_id;

    modport source (output valid, output operation, output request_id, input ready);
    modport sink   (input valid, input operation, input request_id, output ready);
endinterface

interface ipa_out_if;
    import ipa_pkg::*;
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] granted_id;
    logic [ST_W-1:0] status;

    modport source (output valid, output granted_id, output status, input ready);
    modport sink   (input valid, input granted_id, input status, output ready);
endinterface

### hdl/ipa_map.sv
// ipa_map: assigned and released bitmaps as two word-wide synchronous memories
// with registered read and per-row valid bits. Depends on ipa_pkg.
module ipa_map (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [ipa_pkg::ADDR_W-1:0] rd_addr,
    input  ipa_pkg::map_wr_t          wr,
    output ipa_pkg::map_rd_t          rd_data
);
    import ipa_pkg::*;

    word_t assigned_mem [WORD_COUNT];
    word_t released_mem [WORD_COUNT];

    logic [WORD_COUNT-1:0] row_valid_reg;
    logic                  rd_valid_reg;
    word_t                 rd_assigned_reg;
    word_t                 rd_released_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            assigned_mem[wr.addr] <= wr.assigned;
            released_mem[wr.addr] <= wr.released;
        end
        if (rd_en)
        begin
            rd_assigned_reg <= assigned_mem[rd_addr];
            rd_released_reg <= released_mem[rd_addr];
        end
    end

    // rows never written read as clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
                row_valid_reg[wr.addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    assign rd_data.assigned = rd_valid_reg ? rd_assigned_reg : '0;
    assign rd_data.released = rd_valid_reg ? rd_released_reg : '0;

endmodule

### hdl/id_pool_allocator.sv
// id_pool_allocator: top level; sequencer over the bitmap memories in ipa_map.
// Depends on ipa_pkg, ipa_in_if, ipa_out_if and ipa_map.
//
//   channel  dir  fields                 role
//   req      in   operation, request_id  allocate next / specific / release
//   rsp      out  granted_id, status     one word per request
//
// Specific and release: after accept, S_ACCESS reads the word, S_MODIFY writes it back and
// S_REPLY loads the response register; a word rejected at accept (range, void release, unused
// code) goes straight to S_REPLY. Allocate next: after accept, a sweep in S_SCAN of the 16
// bitmap words (one per cycle) finds the lowest released and highest assigned identifier, then
// a read-modify-write of one word (S_ACCESS, S_MODIFY); when exhausted, S_REPLY follows the sweep.
// Reset clears the per-row valid bits at once; a waiting response holds its register while
// the next request is accepted, and that request stalls only at its own response.
module id_pool_allocator (
    input logic       clk,
    input logic       rst_n,
    ipa_in_if.sink    req,
    ipa_out_if.source rsp
);
    import ipa_pkg::*;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] scan_addr_reg, scan_addr_next;
    logic              rel_found_reg, rel_found_next;
    logic [ID_W-1:0]   rel_id_reg, rel_id_next;
    logic [ID_W-1:0]   top_reg, top_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    status_t           pend_st_reg, pend_st_next;
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    status_t           out_st_reg, out_st_next;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    map_wr_t           wr;
    map_rd_t           rd_data;

    logic              out_free;
    logic [ID_W:0]     top_inc;
    word_t             bit_mask;

    ipa_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr      (wr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        cnt_reg       <= cnt_next;
        scan_addr_reg <= scan_addr_next;
        rel_found_reg <= rel_found_next;
        rel_id_reg    <= rel_id_next;
        top_reg       <= top_next;
        pend_id_reg   <= pend_id_next;
        pend_st_reg   <= pend_st_next;
        out_id_reg    <= out_id_next;
        out_st_reg    <= out_st_next;
    end

    assign out_free = !out_valid_reg || rsp.ready;
    assign bit_mask = word_t'(1) << id_reg[BIT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        cnt_next       = cnt_reg;
        scan_addr_next = scan_addr_reg;
        rel_found_next = rel_found_reg;
        rel_id_next    = rel_id_reg;
        top_next       = top_reg;
        pend_id_next   = pend_id_reg;
        pend_st_next   = pend_st_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_id_next    = out_id_reg;
        out_st_next    = out_st_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr             = '0;
        top_inc        = '0;
        req.ready      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next      = req.operation;
                    id_next      = req.request_id;
                    pend_id_next = '0;
                    case (req.operation)
                        OP_NEXT:
                        begin
                            cnt_next       = '0;
                            rel_found_next = 1'b0;
                            top_next       = ID_W'(VOID_ID);
                            state_next     = S_SCAN;
                        end
                        OP_SPECIFIC:
                        begin
                            if ({1'b0, req.request_id} >= (ID_W+1)'(ID_LIMIT))
                            begin
                                pend_st_next = ST_EXHAUSTED;
                                state_next   = S_REPLY;
                            end
                            else
                                state_next = S_ACCESS;
                        end
                        OP_RELEASE:
                        begin
                            if ({1'b0, req.request_id} >= (ID_W+1)'(ID_LIMIT) ||
                                req.request_id == ID_W'(VOID_ID))
                            begin
                                pend_st_next = ST_INVALID;
                                state_next   = S_REPLY;
                            end
                            else
                                state_next = S_ACCESS;
                        end
                        default:
                        begin
                            pend_st_next = ST_INVALID;
                            state_next   = S_REPLY;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (cnt_reg < CNT_W'(WORD_COUNT))
                begin
                    rd_en          = 1'b1;
                    rd_addr        = cnt_reg[ADDR_W-1:0];
                    scan_addr_next = cnt_reg[ADDR_W-1:0];
                end
                if (cnt_reg != '0)
                begin
                    if (!rel_found_reg && rd_data.released != '0)
                    begin
                        rel_found_next = 1'b1;
                        rel_id_next    = {scan_addr_reg, lowest_bit(rd_data.released)};
                    end
                    if (rd_data.assigned != '0)
                        top_next = {scan_addr_reg, highest_bit(rd_data.assigned)};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WORD_COUNT))
                begin
                    top_inc = {1'b0, top_next} + (ID_W+1)'(1);
                    if (rel_found_next)
                    begin
                        id_next    = rel_id_next;
                        state_next = S_ACCESS;
                    end
                    else if (top_inc >= (ID_W+1)'(ID_LIMIT))
                    begin
                        pend_id_next = '0;
                        pend_st_next = ST_EXHAUSTED;
                        state_next   = S_REPLY;
                    end
                    else
                    begin
                        id_next    = top_inc[ID_W-1:0];
                        state_next = S_ACCESS;
                    end
                end
            end

            S_ACCESS:
            begin
                rd_en      = 1'b1;
                rd_addr    = id_reg[ID_W-1:BIT_W];
                state_next = S_MODIFY;
            end

            S_MODIFY:
            begin
                wr.addr      = id_reg[ID_W-1:BIT_W];
                pend_id_next = '0;
                case (op_reg)
                    OP_NEXT:
                    begin
                        wr.en        = 1'b1;
                        wr.assigned  = rd_data.assigned | bit_mask;
                        wr.released  = rd_data.released & ~bit_mask;
                        pend_id_next = id_reg;
                        pend_st_next = ST_OK;
                    end
                    OP_SPECIFIC:
                    begin
                        if ((rd_data.assigned & bit_mask) != '0 || id_reg == ID_W'(VOID_ID))
                            pend_st_next = ST_TAKEN;
                        else
                        begin
                            wr.en        = 1'b1;
                            wr.assigned  = rd_data.assigned | bit_mask;
                            wr.released  = rd_data.released & ~bit_mask;
                            pend_id_next = id_reg;
                            pend_st_next = ST_OK;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if ((rd_data.assigned & bit_mask) == '0)
                            pend_st_next = ST_INVALID;
                        else
                        begin
                            wr.en        = 1'b1;
                            wr.assigned  = rd_data.assigned & ~bit_mask;
                            wr.released  = rd_data.released | bit_mask;
                            pend_id_next = id_reg;
                            pend_st_next = ST_OK;
                        end
                    end
                    default:
                        pend_st_next = ST_INVALID;
                endcase
                state_next = S_REPLY;
            end

            S_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = pend_id_reg;
                    out_st_next    = pend_st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.granted_id = out_id_reg;
    assign rsp.status     = out_st_reg;

endmodule

### hdl/ipa_checker.sv
// ipa_checker: port-level assertions for id_pool_allocator, bound to the top.
// Depends on ipa_pkg and id_pool_allocator.
module ipa_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [ipa_pkg::ID_W-1:0]  granted_id,
    input logic [ipa_pkg::ST_W-1:0]  status
);
    import ipa_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(granted_id) && $stable(status))
        else $error("response word changed while stalled");

    a_ok_nonvoid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> granted_id != ID_W'(VOID_ID))
        else $error("void identifier granted");

    a_fail_void: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> granted_id == ID_W'(VOID_ID))
        else $error("failed request returned an identifier");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in progress");

endmodule

bind id_pool_allocator ipa_checker u_ipa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .granted_id (rsp.granted_id),
    .status     (rsp.status)
);
